>>> hw/rtl/chunked_key_value_store_macros.svh
// Assertion macros shared by the chunked key/value store RTL
`ifndef CHUNKED_KEY_VALUE_STORE_MACROS_SVH
`define CHUNKED_KEY_VALUE_STORE_MACROS_SVH

// same-cycle implication, sampled on clock, off during reset
`define CKVS_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define CKVS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/ckvs_pkg.sv
// Types, constants and codes of the chunked key/value store
package ckvs_pkg;

   localparam int STORE_BYTES_DEF = 1024;
   localparam int HEADER_BYTES    = 8;
   localparam int PTR_W           = 18;
   localparam logic [7:0] MAGIC_RESET = 8'd82;
   localparam logic [7:0] ERASED_BYTE = 8'hFF;

   localparam logic [1:0] REQ_FIND  = 2'd0;
   localparam logic [1:0] REQ_EMPL  = 2'd1;
   localparam logic [1:0] REQ_READ  = 2'd2;
   localparam logic [1:0] REQ_WRITE = 2'd3;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_NO_ROOM = 2'd1;
   localparam logic [1:0] ST_MISSING = 2'd2;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [31:0] key;
      logic [7:0]  record_type;
      logic [9:0]  want_size;
      logic [9:0]  byte_addr;
      logic [7:0]  byte_data;
   } req_item_type;

   typedef struct packed {
      logic        found;
      logic [9:0]  record_addr;
      logic [7:0]  record_kind;
      logic [15:0] record_size;
      logic [1:0]  status;
      logic [7:0]  read_byte;
   } rsp_item_type;

   typedef enum logic [3:0] {
      DP_IDLE,
      DP_CLEAR,
      DP_LATCH,
      DP_BYTE_RD,
      DP_BYTE_WR,
      DP_WALK_START,
      DP_HDR_RD,
      DP_WALK_NEXT,
      DP_TAKE_REC,
      DP_FREE_PREP,
      DP_TERM_PREP,
      DP_FINAL_PREP,
      DP_HDR_WR
   } dp_op_type;

   typedef enum logic [2:0] {
      RSP_NONE,
      RSP_BYTE,
      RSP_EMPTY,
      RSP_HDR,
      RSP_FINAL,
      RSP_NOROOM,
      RSP_MISS
   } rsp_sel_type;

   typedef struct packed {
      dp_op_type   op;
      rsp_sel_type rsp;
   } dp_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic hdr_done;
      logic wr_last;
      logic fits;
      logic hdr_valid;
      logic key_match;
      logic free_match;
      logic room_ok;
      logic rec_small;
   } dp_stat_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_BYTE_RD,
      S_BYTE_RSP,
      S_BYTE_WR,
      S_KEY_START,
      S_KEY_HDR,
      S_KEY_CHK,
      S_EMP_DECIDE,
      S_FREE_WR,
      S_FREE_START,
      S_FREE_HDR,
      S_FREE_CHK,
      S_TERM_WR,
      S_FINAL_PREP,
      S_FINAL_WR
   } state_type;

endpackage

>>> hw/rtl/ckvs_ram.sv
// Generic single-port RAM with registered read data
module ckvs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

>>> hw/rtl/ckvs_datapath.sv
// Datapath of the store: byte RAM, walk pointer, header registers, result register
module ckvs_datapath import ckvs_pkg::*; #(
   parameter int STORE_BYTES = STORE_BYTES_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  req_item_type req_item,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [7:0]   csr_data,
   input  dp_cmd_type   cmd,
   output dp_stat_type  stat,
   output logic         rsp_valid,
   output rsp_item_type rsp_item
);

   localparam int ADDR_W = $clog2(STORE_BYTES);
   localparam logic [PTR_W-1:0] STORE_LIM = PTR_W'(STORE_BYTES);
   localparam logic [PTR_W-1:0] HDR_LEN   = PTR_W'(HEADER_BYTES);

   req_item_type req_ff, req_in;
   logic [9:0]        want_ff, want_in;
   logic [PTR_W-1:0]  ptr_ff, ptr_in;
   logic [ADDR_W-1:0] cnt_ff, cnt_in;
   logic [7:0]        hdr_ff [HEADER_BYTES];
   logic [7:0]        hdr_in [HEADER_BYTES];
   logic [PTR_W-1:0]  rec_addr_ff, rec_addr_in;
   logic [15:0]       rec_size_ff, rec_size_in;
   logic [PTR_W-1:0]  wr_addr_ff, wr_addr_in;
   logic [31:0]       wr_key_ff, wr_key_in;
   logic [15:0]       wr_size_ff, wr_size_in;
   logic [7:0]        wr_kind_ff, wr_kind_in;
   logic [7:0]        magic_ff, magic_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_item_type      rsp_ff, rsp_in;

   logic [31:0]       hdr_key;
   logic [15:0]       hdr_size;
   logic [7:0]        hdr_kind;
   logic [PTR_W-1:0]  byte_wide;
   logic              byte_in_range;
   logic [PTR_W-1:0]  rd_ptr;
   logic [PTR_W-1:0]  wr_ptr;
   logic [ADDR_W-1:0] cnt_m1;
   logic [7:0]        wr_byte;
   logic              ram_we;
   logic [ADDR_W-1:0] ram_addr;
   logic [7:0]        ram_wdata;
   logic [7:0]        ram_rdata;

   ckvs_ram #(.WIDTH(8), .DEPTH(STORE_BYTES)) u_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   assign hdr_key  = {hdr_ff[3], hdr_ff[2], hdr_ff[1], hdr_ff[0]};
   assign hdr_size = {hdr_ff[5], hdr_ff[4]};
   assign hdr_kind = hdr_ff[6];

   assign byte_wide     = PTR_W'(req_ff.byte_addr);
   assign byte_in_range = byte_wide < STORE_LIM;
   assign rd_ptr        = ptr_ff + PTR_W'(cnt_ff);
   assign wr_ptr        = wr_addr_ff + PTR_W'(cnt_ff);
   assign cnt_m1        = cnt_ff - 1'b1;

   always_comb begin
      unique case (cnt_ff[2:0])
         3'd0: wr_byte = wr_key_ff[7:0];
         3'd1: wr_byte = wr_key_ff[15:8];
         3'd2: wr_byte = wr_key_ff[23:16];
         3'd3: wr_byte = wr_key_ff[31:24];
         3'd4: wr_byte = wr_size_ff[7:0];
         3'd5: wr_byte = wr_size_ff[15:8];
         3'd6: wr_byte = wr_kind_ff;
         3'd7: wr_byte = magic_ff;
         default: wr_byte = magic_ff;
      endcase
   end

   assign stat.clear_last = cnt_ff == ADDR_W'(STORE_BYTES - 1);
   assign stat.hdr_done   = cnt_ff == ADDR_W'(HEADER_BYTES);
   assign stat.wr_last    = cnt_ff == ADDR_W'(HEADER_BYTES - 1);
   assign stat.fits       = ptr_ff + HDR_LEN <= STORE_LIM;
   assign stat.hdr_valid  = (hdr_ff[7] == magic_ff) && (hdr_size != 16'd0);
   assign stat.key_match  = hdr_key == req_ff.key;
   assign stat.free_match = (hdr_key == 32'd0) && (hdr_kind == 8'd0)
                            && (hdr_size >= 16'(want_ff));
   assign stat.room_ok    = ptr_ff + HDR_LEN + HDR_LEN + PTR_W'(want_ff) <= STORE_LIM;
   assign stat.rec_small  = rec_size_ff < 16'(want_ff);

   assign csr_ready = 1'b1;
   assign magic_in  = csr_valid ? csr_data : magic_ff;

   always_comb begin
      req_in      = req_ff;
      want_in     = want_ff;
      ptr_in      = ptr_ff;
      cnt_in      = cnt_ff;
      hdr_in      = hdr_ff;
      rec_addr_in = rec_addr_ff;
      rec_size_in = rec_size_ff;
      wr_addr_in  = wr_addr_ff;
      wr_key_in   = wr_key_ff;
      wr_size_in  = wr_size_ff;
      wr_kind_in  = wr_kind_ff;
      ram_we      = 1'b0;
      ram_addr    = rd_ptr[ADDR_W-1:0];
      ram_wdata   = wr_byte;
      unique case (cmd.op)
         DP_IDLE: begin
         end
         DP_CLEAR: begin
            ram_we    = 1'b1;
            ram_addr  = cnt_ff;
            ram_wdata = ERASED_BYTE;
            cnt_in    = cnt_ff + 1'b1;
         end
         DP_LATCH: begin
            req_in  = req_item;
            want_in = (req_item.want_size == 10'd0) ? 10'd1 : req_item.want_size;
         end
         DP_BYTE_RD: begin
            ram_addr = byte_wide[ADDR_W-1:0];
         end
         DP_BYTE_WR: begin
            ram_we    = byte_in_range;
            ram_addr  = byte_wide[ADDR_W-1:0];
            ram_wdata = req_ff.byte_data;
         end
         DP_WALK_START: begin
            ptr_in = '0;
            cnt_in = '0;
         end
         DP_HDR_RD: begin
            // issue byte cnt, capture byte cnt-1 from the previous read
            if (cnt_ff != '0) begin
               hdr_in[cnt_m1[2:0]] = ram_rdata;
            end
            cnt_in = cnt_ff + 1'b1;
         end
         DP_WALK_NEXT: begin
            ptr_in = ptr_ff + HDR_LEN + PTR_W'(hdr_size);
            cnt_in = '0;
         end
         DP_TAKE_REC: begin
            rec_addr_in = ptr_ff;
            rec_size_in = hdr_size;
         end
         DP_FREE_PREP: begin
            wr_addr_in = rec_addr_ff;
            wr_key_in  = 32'd0;
            wr_size_in = rec_size_ff;
            wr_kind_in = 8'd0;
            cnt_in     = '0;
         end
         DP_TERM_PREP: begin
            // terminator goes right after the new record's data
            wr_addr_in  = ptr_ff + HDR_LEN + PTR_W'(want_ff);
            wr_key_in   = 32'd0;
            wr_size_in  = 16'd0;
            wr_kind_in  = 8'd0;
            rec_addr_in = ptr_ff;
            rec_size_in = 16'(want_ff);
            cnt_in      = '0;
         end
         DP_FINAL_PREP: begin
            wr_addr_in = rec_addr_ff;
            wr_key_in  = req_ff.key;
            wr_size_in = rec_size_ff;
            wr_kind_in = req_ff.record_type;
            cnt_in     = '0;
         end
         DP_HDR_WR: begin
            ram_we   = 1'b1;
            ram_addr = wr_ptr[ADDR_W-1:0];
            cnt_in   = cnt_ff + 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = cmd.rsp != RSP_NONE;
      rsp_in       = '0;
      unique case (cmd.rsp)
         RSP_NONE: rsp_in = rsp_ff;
         RSP_BYTE: rsp_in.read_byte = byte_in_range ? ram_rdata : 8'd0;
         RSP_EMPTY: begin
         end
         RSP_HDR: begin
            rsp_in.found       = 1'b1;
            rsp_in.record_addr = ptr_ff[9:0];
            rsp_in.record_kind = hdr_kind;
            rsp_in.record_size = hdr_size;
            rsp_in.status      = ST_OK;
         end
         RSP_FINAL: begin
            rsp_in.found       = 1'b1;
            rsp_in.record_addr = rec_addr_ff[9:0];
            rsp_in.record_kind = req_ff.record_type;
            rsp_in.record_size = rec_size_ff;
            rsp_in.status      = ST_OK;
         end
         RSP_NOROOM: rsp_in.status = ST_NO_ROOM;
         RSP_MISS: rsp_in.status = ST_MISSING;
         default: rsp_in = rsp_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         magic_ff     <= MAGIC_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         magic_ff     <= magic_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      want_ff     <= want_in;
      ptr_ff      <= ptr_in;
      hdr_ff      <= hdr_in;
      rec_addr_ff <= rec_addr_in;
      rec_size_ff <= rec_size_in;
      wr_addr_ff  <= wr_addr_in;
      wr_key_ff   <= wr_key_in;
      wr_size_ff  <= wr_size_in;
      wr_kind_ff  <= wr_kind_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

>>> hw/rtl/ckvs_ctrl.sv
// Controller state machine: sequences the erase, byte accesses, walks, header writes and results
module ckvs_ctrl import ckvs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [1:0]  req_type,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd,
   output logic        busy
);

   state_type state_ff, state_in;
   logic      emp_ff, emp_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         emp_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         emp_ff   <= emp_in;
      end
   end

   assign busy = state_ff != S_IDLE;

   always_comb begin
      state_in = state_ff;
      emp_in   = emp_ff;
      cmd.op   = DP_IDLE;
      cmd.rsp  = RSP_NONE;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.op = DP_CLEAR;
            if (stat.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd.op = DP_LATCH;
               emp_in = req_type == REQ_EMPL;
               unique case (req_type)
                  REQ_FIND:  state_in = S_KEY_START;
                  REQ_EMPL:  state_in = S_KEY_START;
                  REQ_READ:  state_in = S_BYTE_RD;
                  REQ_WRITE: state_in = S_BYTE_WR;
                  default:   state_in = S_IDLE;
               endcase
            end
         end
         S_BYTE_RD: begin
            cmd.op   = DP_BYTE_RD;
            state_in = S_BYTE_RSP;
         end
         S_BYTE_RSP: begin
            cmd.rsp  = RSP_BYTE;
            state_in = S_IDLE;
         end
         S_BYTE_WR: begin
            cmd.op   = DP_BYTE_WR;
            cmd.rsp  = RSP_EMPTY;
            state_in = S_IDLE;
         end
         S_KEY_START: begin
            cmd.op   = DP_WALK_START;
            state_in = S_KEY_HDR;
         end
         S_KEY_HDR: begin
            if (!stat.fits) begin
               // walk left the store: key is absent
               if (emp_ff) begin
                  state_in = S_FREE_START;
               end else begin
                  cmd.rsp  = RSP_MISS;
                  state_in = S_IDLE;
               end
            end else begin
               cmd.op = DP_HDR_RD;
               if (stat.hdr_done) begin
                  state_in = S_KEY_CHK;
               end
            end
         end
         S_KEY_CHK: begin
            priority if (!stat.hdr_valid) begin
               if (emp_ff) begin
                  state_in = S_FREE_START;
               end else begin
                  cmd.rsp  = RSP_MISS;
                  state_in = S_IDLE;
               end
            end else if (stat.key_match) begin
               if (emp_ff) begin
                  cmd.op   = DP_TAKE_REC;
                  state_in = S_EMP_DECIDE;
               end else begin
                  cmd.rsp  = RSP_HDR;
                  state_in = S_IDLE;
               end
            end else begin
               cmd.op   = DP_WALK_NEXT;
               state_in = S_KEY_HDR;
            end
         end
         S_EMP_DECIDE: begin
            if (stat.rec_small) begin
               cmd.op   = DP_FREE_PREP;
               state_in = S_FREE_WR;
            end else begin
               state_in = S_FINAL_PREP;
            end
         end
         S_FREE_WR: begin
            cmd.op = DP_HDR_WR;
            if (stat.wr_last) begin
               state_in = S_FREE_START;
            end
         end
         S_FREE_START: begin
            cmd.op   = DP_WALK_START;
            state_in = S_FREE_HDR;
         end
         S_FREE_HDR: begin
            if (!stat.fits) begin
               cmd.rsp  = RSP_NOROOM;
               state_in = S_IDLE;
            end else begin
               cmd.op = DP_HDR_RD;
               if (stat.hdr_done) begin
                  state_in = S_FREE_CHK;
               end
            end
         end
         S_FREE_CHK: begin
            priority if (!stat.hdr_valid) begin
               // chain end: append here if header, data and terminator fit
               if (stat.room_ok) begin
                  cmd.op   = DP_TERM_PREP;
                  state_in = S_TERM_WR;
               end else begin
                  cmd.rsp  = RSP_NOROOM;
                  state_in = S_IDLE;
               end
            end else if (stat.free_match) begin
               cmd.op   = DP_TAKE_REC;
               state_in = S_FINAL_PREP;
            end else begin
               cmd.op   = DP_WALK_NEXT;
               state_in = S_FREE_HDR;
            end
         end
         S_TERM_WR: begin
            cmd.op = DP_HDR_WR;
            if (stat.wr_last) begin
               state_in = S_FINAL_PREP;
            end
         end
         S_FINAL_PREP: begin
            cmd.op   = DP_FINAL_PREP;
            state_in = S_FINAL_WR;
         end
         S_FINAL_WR: begin
            cmd.op = DP_HDR_WR;
            if (stat.wr_last) begin
               cmd.rsp  = RSP_FINAL;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

>>> hw/rtl/chunked_key_value_store.sv
// Byte read: states S_BYTE_RD and S_BYTE_RSP, then the registered result strobe; byte
// write: state S_BYTE_WR, then the strobe. Find walks the chain header by header. Emplace:
// one or two walks plus header writes. Header bytes come one per cycle (one RAM port).
// One item at a time; busy falls at the edge that raises the item's result strobe.
// Synchronous reset: after reset the RAM is erased to 0xFF, one byte per cycle, with busy
// high; csr writes are taken throughout.
module chunked_key_value_store import ckvs_pkg::*; #(
   parameter int STORE_BYTES = STORE_BYTES_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_item_type req_item,
   output logic         rsp_valid,
   output rsp_item_type rsp_item,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [7:0]   csr_data
);

`include "chunked_key_value_store_macros.svh"

   dp_cmd_type  cmd;
   dp_stat_type stat;

   ckvs_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_type (req_item.req_type),
      .stat     (stat),
      .cmd      (cmd),
      .busy     (busy)
   );

   ckvs_datapath #(.STORE_BYTES(STORE_BYTES)) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   `CKVS_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted transfer did not raise busy")
   `CKVS_ASSERT_SAME(a_rsp_after_busy, rsp_valid, $past(busy), "result without work in flight")
   `CKVS_ASSERT_NEXT(a_rsp_single, rsp_valid, !rsp_valid, "result strobe held two cycles")
   `CKVS_ASSERT_SAME(a_fail_no_record, rsp_valid && (rsp_item.status != ST_OK),
                     !rsp_item.found, "failed result flags a record")

endmodule

>>> tb/tb_chunked_key_value_store.sv
// Testbench for the chunked key/value record store: directed and random requests against a predictor
module tb_chunked_key_value_store;
   import ckvs_pkg::*;

   localparam int STORE = STORE_BYTES_DEF;
   localparam int STALL_LIMIT = 60000;

   typedef struct {
      bit          valid;
      int unsigned addr;
      int unsigned key;
      int unsigned size;
      int unsigned kind;
   } header_view_type;

   logic         clock;
   logic         reset;
   logic         start;
   logic         busy;
   req_item_type req_item;
   logic         rsp_valid;
   rsp_item_type rsp_item;
   logic         csr_valid;
   logic         csr_ready;
   logic [7:0]   csr_data;

   logic [7:0]   store_image [STORE];
   logic [7:0]   magic_shadow;
   rsp_item_type pending_rsp [$];
   logic [31:0]  key_pool [8];
   int           error_count;
   int           stall_cycles;
   bit           gaps_on;

   chunked_key_value_store dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_item(req_item),
      .rsp_valid(rsp_valid), .rsp_item(rsp_item),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   // ---------------- predictor ----------------
   function automatic header_view_type load_header(int unsigned a);
      header_view_type h;
      h.addr  = a;
      h.key   = {store_image[a+3], store_image[a+2], store_image[a+1], store_image[a]};
      h.size  = {store_image[a+5], store_image[a+4]};
      h.kind  = store_image[a+6];
      h.valid = (store_image[a+7] == magic_shadow) && (h.size != 0);
      return h;
   endfunction

   function automatic void store_header(int unsigned a, int unsigned k, int unsigned size,
                                        int unsigned kind);
      if (a + HEADER_BYTES <= STORE) begin
         store_image[a]   = k[7:0];
         store_image[a+1] = k[15:8];
         store_image[a+2] = k[23:16];
         store_image[a+3] = k[31:24];
         store_image[a+4] = size[7:0];
         store_image[a+5] = size[15:8];
         store_image[a+6] = kind[7:0];
         store_image[a+7] = magic_shadow;
      end
   endfunction

   // search the chain by key, or for a free record of at least need bytes
   function automatic header_view_type search_chain(bit want_free, int unsigned k,
                                                    int unsigned need);
      header_view_type none;
      header_view_type h;
      int unsigned a;
      none = '{default: 0};
      a = 0;
      while (a + HEADER_BYTES <= STORE) begin
         h = load_header(a);
         if (!h.valid) return none;
         if (!want_free && h.key == k) return h;
         if (want_free && h.key == 0 && h.kind == 0 && h.size >= need) return h;
         a = a + HEADER_BYTES + h.size;
      end
      return none;
   endfunction

   function automatic bit locate_chain_end(output int unsigned end_addr);
      header_view_type h;
      int unsigned a;
      a = 0;
      end_addr = 0;
      while (a + HEADER_BYTES <= STORE) begin
         h = load_header(a);
         if (!h.valid) begin
            end_addr = a;
            return 1'b1;
         end
         a = a + HEADER_BYTES + h.size;
      end
      return 1'b0;
   endfunction

   function automatic rsp_item_type predict_store_rsp(req_item_type r);
      rsp_item_type    o;
      header_view_type h;
      int unsigned     want;
      int unsigned     end_addr;
      bit              ok;
      o = '0;
      case (r.req_type)
         REQ_FIND: begin
            h = search_chain(1'b0, r.key, 0);
            if (h.valid) begin
               o.found = 1'b1;
               o.record_addr = h.addr[9:0];
               o.record_kind = h.kind[7:0];
               o.record_size = h.size[15:0];
            end else begin
               o.status = ST_MISSING;
            end
         end
         REQ_EMPL: begin
            ok = 1'b1;
            want = (r.want_size == 0) ? 1 : r.want_size;
            h = search_chain(1'b0, r.key, 0);
            if (h.valid && h.size < want) begin
               store_header(h.addr, 0, h.size, 0);
               h.valid = 1'b0;
            end
            if (!h.valid) begin
               h = search_chain(1'b1, 0, want);
               if (!h.valid) begin
                  if (locate_chain_end(end_addr) &&
                      end_addr + 2 * HEADER_BYTES + want <= STORE) begin
                     store_header(end_addr + HEADER_BYTES + want, 0, 0, 0);
                     h.valid = 1'b1;
                     h.addr = end_addr;
                     h.size = want;
                  end else begin
                     ok = 1'b0;
                  end
               end
            end
            if (ok) begin
               store_header(h.addr, r.key, h.size, r.record_type);
               o.found = 1'b1;
               o.record_addr = h.addr[9:0];
               o.record_kind = r.record_type;
               o.record_size = h.size[15:0];
            end else begin
               o.status = ST_NO_ROOM;
            end
         end
         REQ_READ: begin
            if (r.byte_addr < STORE) o.read_byte = store_image[r.byte_addr];
         end
         default: begin
            if (r.byte_addr < STORE) store_image[r.byte_addr] = r.byte_data;
         end
      endcase
      return o;
   endfunction

   // ---------------- checking ----------------
   task automatic check_field(string name, int unsigned exp_val, int unsigned act_val);
      if (exp_val != act_val) begin
         $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_val, act_val);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_item_type exp_rsp;
      if (!reset && rsp_valid) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected result: expected none, actual %h", $time, rsp_item);
            error_count++;
         end else begin
            exp_rsp = pending_rsp.pop_front();
            check_field("found", exp_rsp.found, rsp_item.found);
            check_field("record_addr", exp_rsp.record_addr, rsp_item.record_addr);
            check_field("record_kind", exp_rsp.record_kind, rsp_item.record_kind);
            check_field("record_size", exp_rsp.record_size, rsp_item.record_size);
            check_field("status", exp_rsp.status, rsp_item.status);
            check_field("read_byte", exp_rsp.read_byte, rsp_item.read_byte);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t: watchdog expired", $time);
         $display("Test completed with failures");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // ---------------- driving ----------------
   task automatic send_req(logic [1:0] kind, logic [31:0] k, logic [7:0] rtype,
                           logic [9:0] want, logic [9:0] addr, logic [7:0] data);
      req_item_type r;
      r.req_type = kind;
      r.key = k;
      r.record_type = rtype;
      r.want_size = want;
      r.byte_addr = addr;
      r.byte_data = data;
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         @(negedge clock);
         start = 1'b0;
         repeat ($urandom_range(1, 17)) @(negedge clock);
      end else begin
         @(negedge clock);
      end
      start = 1'b1;
      req_item = r;
      do @(posedge clock); while (busy);
      pending_rsp.push_back(predict_store_rsp(r));
   endtask

   task automatic drain_results();
      @(negedge clock);
      start = 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   task automatic write_magic(logic [7:0] value);
      drain_results();
      while (busy) @(posedge clock);
      repeat (4) @(posedge clock);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_data = value;
      do @(posedge clock); while (!csr_ready);
      magic_shadow = value;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // ---------------- tests ----------------
   task automatic test_erased_store();
      send_req(REQ_FIND, 32'h0, 8'h0, 10'd0, 10'd0, 8'h0);
      send_req(REQ_FIND, 32'hFFFF_FFFF, 8'h0, 10'd0, 10'd0, 8'h0);
      send_req(REQ_EMPL, 32'h1, 8'h0, 10'd1, 10'd0, 8'h0);
      send_req(REQ_EMPL, 32'h0, 8'h0, 10'd1023, 10'd0, 8'h0);
      send_req(REQ_EMPL, 32'hFFFF_FFFF, 8'hFF, 10'd0, 10'd0, 8'h0);
      send_req(REQ_FIND, 32'hFFFF_FFFF, 8'h0, 10'd0, 10'd0, 8'h0);
   endtask

   task automatic test_regrow_and_reuse();
      send_req(REQ_EMPL, 32'h1234_5678, 8'h07, 10'd20, 10'd0, 8'h0);
      send_req(REQ_EMPL, 32'h1, 8'h33, 10'd30, 10'd0, 8'h0);
      drain_results();
      send_req(REQ_EMPL, 32'hAB, 8'h44, 10'd1, 10'd0, 8'h0);
      send_req(REQ_FIND, 32'hAB, 8'h0, 10'd0, 10'd0, 8'h0);
      send_req(REQ_FIND, 32'h1, 8'h0, 10'd0, 10'd0, 8'h0);
      send_req(REQ_EMPL, 32'h55, 8'h01, 10'd1016, 10'd0, 8'h0);
      send_req(REQ_EMPL, 32'h56, 8'h02, 10'd512, 10'd0, 8'h0);
   endtask

   task automatic test_byte_access();
      send_req(REQ_READ, 32'h0, 8'h0, 10'd0, 10'd0, 8'h0);
      send_req(REQ_WRITE, 32'h0, 8'h0, 10'd0, 10'd1023, 8'hA5);
      send_req(REQ_READ, 32'h0, 8'h0, 10'd0, 10'd1023, 8'h0);
      send_req(REQ_WRITE, 32'h0, 8'h0, 10'd0, 10'd600, 8'h00);
      send_req(REQ_READ, 32'h0, 8'h0, 10'd0, 10'd600, 8'h0);
   endtask

   // head record whose size runs the walk off the end of the store
   task automatic test_runaway_chain();
      logic [7:0] hdr [8];
      hdr = '{8'h11, 8'h00, 8'h00, 8'h00, 8'hF4, 8'h03, 8'h01, magic_shadow};
      for (int i = 0; i < 8; i++) send_req(REQ_WRITE, 32'h0, 8'h0, 10'd0, i[9:0], hdr[i]);
      send_req(REQ_FIND, 32'h22, 8'h0, 10'd0, 10'd0, 8'h0);
      send_req(REQ_EMPL, 32'h22, 8'h05, 10'd1, 10'd0, 8'h0);
      send_req(REQ_FIND, 32'h11, 8'h0, 10'd0, 10'd0, 8'h0);
      send_req(REQ_WRITE, 32'h0, 8'h0, 10'd0, 10'd7, 8'h00);
   endtask

   task automatic test_random_traffic(int count);
      int pick;
      logic [31:0] k;
      logic [9:0] want;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 99) == 0) drain_results();
         pick = $urandom_range(0, 99);
         k = ($urandom_range(0, 4) == 0) ? $urandom() : key_pool[$urandom_range(0, 7)];
         case ($urandom_range(0, 19))
            0: want = $urandom_range(0, 1023);
            1, 2, 3: want = $urandom_range(49, 200);
            default: want = $urandom_range(1, 48);
         endcase
         if (pick < 30)
            send_req(REQ_FIND, k, 8'h0, 10'd0, 10'd0, 8'h0);
         else if (pick < 62)
            send_req(REQ_EMPL, k, ($urandom_range(0, 3) == 0) ? 8'h0 : $urandom_range(0, 255),
                     want, 10'd0, 8'h0);
         else if (pick < 86)
            send_req(REQ_READ, 32'h0, 8'h0, 10'd0, $urandom_range(0, 1023), 8'h0);
         else if (pick < 88)
            // break the chain at its head so the store can fill again
            send_req(REQ_WRITE, 32'h0, 8'h0, 10'd0, 10'd7, $urandom_range(0, 255));
         else
            send_req(REQ_WRITE, 32'h0, 8'h0, 10'd0, $urandom_range(0, 1023),
                     $urandom_range(0, 255));
      end
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_item = '0;
      csr_valid = 1'b0;
      csr_data = 8'h0;
      error_count = 0;
      gaps_on = 1'b1;
      magic_shadow = MAGIC_RESET;
      for (int i = 0; i < STORE; i++) store_image[i] = ERASED_BYTE;
      key_pool[0] = 32'h0;
      key_pool[1] = 32'hFFFF_FFFF;
      for (int i = 2; i < 8; i++) key_pool[i] = $urandom();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      while (busy) @(posedge clock);

      write_magic(MAGIC_RESET);
      test_erased_store();
      test_regrow_and_reuse();
      test_byte_access();
      test_runaway_chain();
      test_random_traffic(250);
      write_magic(8'h00);
      test_random_traffic(120);
      write_magic(8'hFF);
      test_random_traffic(60);
      write_magic($urandom_range(1, 254));
      test_random_traffic(150);
      write_magic(MAGIC_RESET);
      test_random_traffic(120);
      gaps_on = 1'b0;
      test_random_traffic(100);

      drain_results();
      repeat (50) @(posedge clock);
      if (error_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/ckvs_pkg.sv
hw/rtl/ckvs_ram.sv
hw/rtl/ckvs_datapath.sv
hw/rtl/ckvs_ctrl.sv
hw/rtl/chunked_key_value_store.sv
tb/tb_chunked_key_value_store.sv
